// ===== rtl/core/rcfp_pkg.sv =====
package rcfp_pkg;

  // Frame layout
  localparam int unsigned NUM_CHANNELS = 14;
  localparam int unsigned DATA_BYTES   = 2 * NUM_CHANNELS;
  localparam int unsigned FINAL_POS    = DATA_BYTES + 1;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned CHAN_W = 4;

  // Internal widths
  localparam int unsigned POS_W      = $clog2(FINAL_POS + 1);
  localparam int unsigned CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Frame constants
  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h20;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h40;
  localparam logic [VAL_W-1:0]  SUM_INIT   = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic hdr_first;   // first header seen: preset checksum
    logic hdr_second;  // second header seen: start data collection
    logic data_byte;   // channel, checksum low byte
    logic out_chan;    // load next channel result
    logic out_err;     // load error result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_hdr_first;
    logic is_hdr_second;
    logic pos_final;
    logic sum_ok;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/rcfp_ctrl.sv =====
module rcfp_ctrl
  import rcfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] ST_WAIT1 = 2'd0;
  localparam logic [1:0] ST_WAIT2 = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_fire;

  // Hold off input while the channel run drains or the output register is full
  assign in_ready_o = status_i.out_free && (state_q != ST_EMIT);
  assign in_fire    = in_valid_i && in_ready_o;

  // Advance the parse and emit sequence
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_WAIT1: begin
        if (in_fire && status_i.is_hdr_first) begin
          cmd_o.hdr_first = 1'b1;
          state_d         = ST_WAIT2;
        end
      end
      ST_WAIT2: begin
        if (in_fire) begin
          if (status_i.is_hdr_second) begin
            cmd_o.hdr_second = 1'b1;
            state_d          = ST_DATA;
          end else begin
            state_d = ST_WAIT1;
          end
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          if (!status_i.pos_final) begin
            cmd_o.data_byte = 1'b1;
          end else if (status_i.sum_ok) begin
            cmd_o.out_chan = 1'b1;
            state_d        = status_i.emit_last ? ST_WAIT1 : ST_EMIT;
          end else begin
            cmd_o.out_err = 1'b1;
            state_d       = ST_WAIT1;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_chan = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_WAIT1;
          end
        end
      end
      default: begin
        state_d = ST_WAIT1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT1;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // A result is loaded only on the final byte or during the run
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_chan || cmd_o.out_err) |-> (state_q == ST_EMIT || state_q == ST_DATA))
    else $error("result loaded outside frame end");

  // The run ends back at header search
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && status_i.out_free && status_i.emit_last) |=>
      (state_q == ST_WAIT1))
    else $error("run did not end at header search");

  // Data collection begins only from the second header
  a_data_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DATA) ##1 (state_q == ST_DATA) |-> $past(cmd_o.hdr_second))
    else $error("data phase entered without second header");
`endif

endmodule

// ===== rtl/core/rcfp_datapath.sv =====
module rcfp_datapath
  import rcfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAN_W-1:0] channel_index_o,
  output logic [VAL_W-1:0]  channel_value_o,
  output logic              frame_error_o,
  output logic              run_last_o
);

  logic [POS_W-1:0]    pos_q;
  logic [VAL_W-1:0]    sum_q;
  logic [BYTE_W-1:0]   low_q;
  logic [VAL_W-1:0]    store_q [NUM_CHANNELS];
  logic [CH_IDX_W-1:0] emit_idx_q;

  logic                out_valid_q;
  logic [CHAN_W-1:0]   out_index_q;
  logic [VAL_W-1:0]    out_value_q;
  logic                out_error_q;
  logic                out_last_q;

  logic                pos_data;
  logic                out_free;
  logic                emit_last;
  logic [VAL_W-1:0]    sum_sub;

  assign pos_data  = (pos_q < POS_W'(DATA_BYTES));
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_last = (emit_idx_q == CH_IDX_W'(NUM_CHANNELS - 1));
  assign sum_sub   = sum_q - {{(VAL_W-BYTE_W){1'b0}}, rx_byte_i};

  assign status_o.is_hdr_first  = (rx_byte_i == HDR_FIRST);
  assign status_o.is_hdr_second = (rx_byte_i == HDR_SECOND);
  assign status_o.pos_final     = (pos_q == POS_W'(FINAL_POS));
  assign status_o.sum_ok        = ({rx_byte_i, low_q} == sum_q);
  assign status_o.emit_last     = emit_last;
  assign status_o.out_free      = out_free;

  // Track byte position, checksum, the pending low byte and the emit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= SUM_INIT;
      low_q      <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.hdr_first) begin
        sum_q <= SUM_INIT - {{(VAL_W-BYTE_W){1'b0}}, HDR_FIRST};
      end
      if (cmd_i.hdr_second) begin
        sum_q      <= sum_sub;
        pos_q      <= '0;
        emit_idx_q <= '0;
      end
      if (cmd_i.data_byte) begin
        pos_q <= pos_q + POS_W'(1);
        if (pos_data) begin
          sum_q <= sum_sub;
        end
        if (!pos_data || !pos_q[0]) begin
          low_q <= rx_byte_i;
        end
      end
      if (cmd_i.out_chan || cmd_i.out_err) begin
        pos_q <= '0;
      end
      if (cmd_i.out_chan && !emit_last) begin
        emit_idx_q <= emit_idx_q + CH_IDX_W'(1);
      end
    end
  end

  // Write a channel value on the high byte of each pair
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_byte && pos_data && pos_q[0]) begin
      store_q[pos_q[CH_IDX_W:1]] <= {rx_byte_i, low_q};
    end
  end

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_chan || cmd_i.out_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_err) begin
      out_index_q <= '0;
      out_value_q <= '0;
      out_error_q <= 1'b1;
      out_last_q  <= 1'b1;
    end else if (cmd_i.out_chan) begin
      out_index_q <= CHAN_W'(emit_idx_q);
      out_value_q <= store_q[emit_idx_q];
      out_error_q <= 1'b0;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_index_q;
  assign channel_value_o = out_value_q;
  assign frame_error_o   = out_error_q;
  assign run_last_o      = out_last_q;

`ifndef SYNTHESIS
  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_chan || cmd_i.out_err) |-> out_free)
    else $error("result overwritten before transaction");

  // An error result is a run of one with empty payload
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_err |=> (out_last_q && out_index_q == '0 && out_value_q == '0))
    else $error("malformed error result");

  // Channel and error loads exclude each other
  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.out_chan && cmd_i.out_err))
    else $error("channel and error load together");
`endif

endmodule

// ===== rtl/core/rc_serial_frame_parser.sv =====
// Byte-serial receiver for the 32-byte RC frame: header 0x20 0x40, fourteen
// little-endian 16-bit channels, then a little-endian checksum equal to 0xFFFF
// minus all preceding bytes. The final byte of a frame yields either one
// error result or a run of NUM_CHANNELS channel results, one per cycle while
// the output side is ready, through a single output register; input is held
// off until the last channel result is loaded into that register.
module rc_serial_frame_parser
  import rcfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAN_W-1:0] channel_index_o,
  output logic [VAL_W-1:0]  channel_value_o,
  output logic              frame_error_o,
  output logic              run_last_o
);

  cmd_t    cmd;
  status_t status;

  // Parse and run sequencing
  rcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Checksum, channel store and output register
  rcfp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .frame_error_o   (frame_error_o),
    .run_last_o      (run_last_o)
  );

endmodule

// ===== verif/rc_serial_frame_parser_tb.sv =====
`timescale 1ns / 100ps

module rc_serial_frame_parser_tb;
  import rcfp_pkg::*;

  localparam int RANDOM_ITEMS = 90;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  // Parser phases tracked by the frame predictor
  typedef enum logic [1:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    COLLECT
  } parse_state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] idx;
    logic [VAL_W-1:0]  value;
    logic              err;
    logic              last;
  } chan_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [BYTE_W-1:0] rx_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CHAN_W-1:0] channel_index_o;
  logic [VAL_W-1:0]  channel_value_o;
  logic              frame_error_o;
  logic              run_last_o;

  // Frame predictor state
  parse_state_e      frame_phase;
  logic [4:0]        frame_pos;
  logic [VAL_W-1:0]  frame_sum;
  logic [BYTE_W-1:0] held_low;
  logic [VAL_W-1:0]  chan_vals [NUM_CHANNELS];

  chan_result_t      expected_results [$];
  logic [VAL_W-1:0]  frame_chans [NUM_CHANNELS];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  bytes_sent = 0;
  int  next_gap = 0;
  int  hold_off_cycles = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;

  rc_serial_frame_parser DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .frame_error_o   (frame_error_o),
    .run_last_o      (run_last_o)
  );

  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit enable);
    int r;
    r = $urandom_range(0, 99);
    if (!enable || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_chan_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    return VAL_W'($urandom_range(0, 65535));
  endfunction

  // Advance the predictor by one accepted byte and queue any results it causes
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    chan_result_t r;
    case (frame_phase)
      SEEK_SECOND: begin
        if (b == HDR_SECOND) begin
          frame_sum   = frame_sum - b;
          frame_pos   = '0;
          frame_phase = COLLECT;
        end else begin
          frame_phase = SEEK_FIRST;
        end
      end
      COLLECT: begin
        if (frame_pos < DATA_BYTES) begin
          if (!frame_pos[0]) held_low = b;
          else chan_vals[frame_pos >> 1] = {b, held_low};
          frame_sum = frame_sum - b;
          frame_pos = frame_pos + 1'b1;
        end else if (frame_pos == DATA_BYTES) begin
          held_low  = b;
          frame_pos = frame_pos + 1'b1;
        end else begin
          // checksum high byte closes the frame
          frame_phase = SEEK_FIRST;
          frame_pos   = '0;
          if ({b, held_low} != frame_sum) begin
            r.idx   = '0;
            r.value = '0;
            r.err   = 1'b1;
            r.last  = 1'b1;
            expected_results.push_back(r);
          end else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              r.idx   = CHAN_W'(i);
              r.value = chan_vals[i];
              r.err   = 1'b0;
              r.last  = (i == NUM_CHANNELS - 1);
              expected_results.push_back(r);
            end
          end
        end
      end
      default: begin
        if (b == HDR_FIRST) begin
          frame_sum   = SUM_INIT - HDR_FIRST;
          frame_phase = SEEK_SECOND;
        end else begin
          frame_phase = SEEK_FIRST;
        end
      end
    endcase
  endfunction

  // Offer one byte, hold it until the transaction completes, then predict
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    repeat (next_gap) @(posedge clk_i);
    rx_byte_i  <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b);
    bytes_sent++;
    next_gap = pick_gap(tx_idle_en);
    if (next_gap > 0) in_valid_i <= 1'b0;
  endtask

  // Drop valid when no byte follows right away
  task automatic end_burst();
    if (next_gap == 0) in_valid_i <= 1'b0;
  endtask

  // Feed filler until the parser waits for a header again
  task automatic resync_parser();
    while (frame_phase != SEEK_FIRST) send_byte('0);
  endtask

  // Send a full frame from frame_chans, optionally with a broken checksum
  task automatic send_frame(input bit corrupt_sum);
    logic [VAL_W-1:0] sum;
    resync_parser();
    sum = SUM_INIT - HDR_FIRST - HDR_SECOND;
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      send_byte(frame_chans[i][7:0]);
      send_byte(frame_chans[i][15:8]);
      sum = sum - frame_chans[i][7:0] - frame_chans[i][15:8];
    end
    if (corrupt_sum) sum = sum ^ VAL_W'($urandom_range(1, 65535));
    send_byte(sum[7:0]);
    send_byte(sum[15:8]);
  endtask

  task automatic fill_random_chans();
    for (int i = 0; i < NUM_CHANNELS; i++) frame_chans[i] = pick_chan_value();
  endtask

  // Check results; stall at random or for a requested hold-off
  initial begin : result_monitor
    chan_result_t want;
    chan_result_t got;
    int stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.idx   = channel_index_o;
        got.value = channel_value_o;
        got.err   = frame_error_o;
        got.last  = run_last_o;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result idx=%0d val=%h err=%b last=%b", $realtime,
                     got.idx, got.value, got.err, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got.idx !== want.idx || got.value !== want.value ||
              got.err !== want.err || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: mismatch exp idx=%0d val=%h err=%b last=%b,",
                       $realtime, want.idx, want.value, want.err, want.last,
                       " got idx=%0d val=%h err=%b last=%b",
                       got.idx, got.value, got.err, got.last);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap(rx_idle_en);
      end
    end
  end

  // Bytes outside a frame, a stray second header and broken header pairs
  task automatic test_stray_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_SECOND);
    // repeated first header is consumed, so the 0x40 after it is ignored
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_FIRST);
    send_byte(8'h41);
  endtask

  // Good frame with extreme values and header codes inside the data
  task automatic test_good_frame();
    fill_random_chans();
    frame_chans[0] = 16'h0000;
    frame_chans[1] = 16'hFFFF;
    frame_chans[2] = 16'h0001;
    frame_chans[3] = 16'h8000;
    frame_chans[4] = {HDR_SECOND, HDR_FIRST};
    frame_chans[5] = {HDR_FIRST, HDR_SECOND};
    send_frame(1'b0);
  endtask

  // All-ones frame with a bad checksum, then the same frame intact
  task automatic test_checksum_error();
    for (int i = 0; i < NUM_CHANNELS; i++) frame_chans[i] = '1;
    send_frame(1'b1);
    send_frame(1'b0);
  endtask

  // Mostly well-formed frames, the rest broken frames and noise
  task automatic test_random_traffic();
    int start;
    int pick;
    int count;
    logic [BYTE_W-1:0] b;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      tx_idle_en = ($urandom_range(0, 99) >= 15);
      rx_idle_en = ($urandom_range(0, 99) >= 15);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        fill_random_chans();
        send_frame(1'b0);
      end else if (pick < 75) begin
        fill_random_chans();
        send_frame(1'b1);
      end else if (pick < 83) begin
        // truncated frame, finished off by the next resync
        resync_parser();
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        count = $urandom_range(1, DATA_BYTES + 1);
        repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        b = BYTE_W'($urandom_range(0, 255));
        if (b == HDR_SECOND) b = HDR_FIRST;
        send_byte(HDR_FIRST);
        send_byte(b);
      end else begin
        count = $urandom_range(1, 4);
        repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the output off while frames keep coming, so the input stalls
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    hold_off_cycles = 800;
    repeat (2) begin
      fill_random_chans();
      send_frame(1'b0);
    end
    tx_idle_en = 1'b1;
  endtask

  // Back-to-back frames with no idling on either side
  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (3) begin
      fill_random_chans();
      send_frame(1'b0);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    out_ready_i = 1'b0;
    frame_phase = SEEK_FIRST;
    frame_pos   = '0;
    frame_sum   = SUM_INIT;
    held_low    = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) chan_vals[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stray_bytes();
    test_good_frame();
    test_checksum_error();
    test_random_traffic();
    test_output_backpressure();
    test_streaming();
    resync_parser();
    end_burst();

    // Drain outstanding results, then let the block settle
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rcfp_pkg.sv
rtl/core/rcfp_ctrl.sv
rtl/core/rcfp_datapath.sv
rtl/core/rc_serial_frame_parser.sv
verif/rc_serial_frame_parser_tb.sv
